[rtl/prs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Precharge relay sequencer package
// Widths, delays, mode and register codes and the tick/result types.
// ----------------------------------------------------------------------------
package prs_pkg;

	// Voltage and register widths
	localparam int VOLT_WIDTH = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CMP_W      = ((VOLT_WIDTH > CFG_W) ? VOLT_WIDTH : CFG_W) + 1;

	// Sequencing delays in ticks
	localparam int RELAY_DELAY_TICKS  = 10;
	localparam int BYPASS_DELAY_TICKS = 200;
	localparam int HOLD_DUTY_TICKS    = 1000;

	localparam int RELAY_TMR_W  = $clog2(RELAY_DELAY_TICKS + 1);
	localparam int BYPASS_TMR_W = $clog2(BYPASS_DELAY_TICKS + 1);
	localparam int HOLD_TMR_W   = $clog2(HOLD_DUTY_TICKS + 1);

	// Operating modes
	localparam logic [1:0] MODE_OTHER  = 2'd0;
	localparam logic [1:0] MODE_BOOST  = 2'd1;
	localparam logic [1:0] MODE_BUCK   = 2'd2;
	localparam logic [1:0] MODE_BYPASS = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STOP_DELTA    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BATT_LEVEL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_TICKS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS_START  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS_STOP   = 3'd4;

	// Stream payload widths
	localparam int IN_BITS     = 3 * VOLT_WIDTH + 2;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = 7;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef logic [VOLT_WIDTH-1:0] volt_t;
	typedef logic [CFG_W-1:0]      cfg_word_t;

	typedef struct packed {
		logic  [1:0] mode;
		volt_t       low_side_volts;
		volt_t       converter_low_volts;
		volt_t       high_side_volts;
		logic        bypass_request;
		logic        error_reset;
	} tick_t;

	typedef struct packed {
		logic three_low_duty;
		logic two_low_duty;
		logic precharge_abort_flag;
		logic precharge_finished;
		logic relay_three_closed;
		logic relay_two_closed;
		logic relay_one_closed;
	} result_t;

endpackage
`default_nettype wire

[rtl/precharge_relay_sequencer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Precharge relay sequencer
// Drives the precharge (S1), main (S2) and bypass (S3) relay commands and
// their hold-duty flags from one control tick per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_* takes one control tick per transaction; mode is in
//   tuser, voltages and the request/reset flags are in tdata. Master stream
//   m_axis_* returns exactly one result per tick: the relay commands and
//   status bits as they stand after that tick.
//   The cfg_* channel writes the five threshold registers (always ready);
//   write only while no tick is in flight. Unknown indexes are ignored.
//   The tick sits in the input register after the accepting edge; once the
//   result register is free, the sequencing logic updates its timers and
//   loads the result register, and the result is valid from then.
//   Throughput is one tick per cycle while the receiver takes results, set
//   by the state update between those two registers.
//   Reset opens all relays, clears every timer and status bit and restores
//   the register defaults. When the receiver stalls the result register
//   holds; the input register still takes one more tick, then s_axis_tready
//   drops until the result is taken.
// ----------------------------------------------------------------------------
module precharge_relay_sequencer_top (
	input  wire                               clk,
	input  wire                               arst_n,
	// Config write channel
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [prs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [prs_pkg::CFG_W-1:0]         cfg_data,
	// Tick input stream
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: low_side_volts, converter_low_volts, high_side_volts,
	//        bypass_request, error_reset, zero pad
	input  wire  [prs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// tuser: mode
	input  wire  [1:0]                        s_axis_tuser,
	// Result stream
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// tdata: relay_one_closed, relay_two_closed, relay_three_closed,
	//        precharge_finished, precharge_abort_flag, two_low_duty,
	//        three_low_duty, zero pad
	output logic [prs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import prs_pkg::*;

	localparam int LOW_LSB  = 0;
	localparam int CONV_LSB = VOLT_WIDTH;
	localparam int HIGH_LSB = 2 * VOLT_WIDTH;
	localparam int REQ_BIT  = 3 * VOLT_WIDTH;
	localparam int ERR_BIT  = 3 * VOLT_WIDTH + 1;

	localparam logic [RELAY_TMR_W-1:0]  RELAY_MAX  = RELAY_TMR_W'(RELAY_DELAY_TICKS);
	localparam logic [BYPASS_TMR_W-1:0] BYPASS_MAX = BYPASS_TMR_W'(BYPASS_DELAY_TICKS);
	localparam logic [HOLD_TMR_W-1:0]   HOLD_MAX   = HOLD_TMR_W'(HOLD_DUTY_TICKS);

	// Configuration registers
	cfg_word_t stop_delta_q, batt_level_q, limit_ticks_q, byp_start_q, byp_stop_q;

	// Pipeline registers
	tick_t   tick_s1;
	logic    valid_s1;
	result_t res_q;
	logic    res_valid_q;
	logic    advance;

	// Sequencer state
	logic [RELAY_TMR_W-1:0]  close_two_tmr_q, open_one_tmr_q;
	logic                    open_one_pend_q;
	logic [CFG_W-1:0]        abort_tmr_q;
	logic [BYPASS_TMR_W-1:0] bypass_tmr_q;
	logic [HOLD_TMR_W-1:0]   hold_two_tmr_q, hold_three_tmr_q;
	logic                    cmd_one_q, cmd_two_q, cmd_three_q;
	logic                    finished_q, aborted_q, low_two_q, low_three_q;

	// Next-state values
	logic [RELAY_TMR_W-1:0]  close_two_tmr_d, open_one_tmr_d;
	logic                    open_one_pend_d;
	logic [CFG_W-1:0]        abort_tmr_d;
	logic [BYPASS_TMR_W-1:0] bypass_tmr_d;
	logic [HOLD_TMR_W-1:0]   hold_two_tmr_d, hold_three_tmr_d;
	logic                    cmd_one_d, cmd_two_d, cmd_three_d;
	logic                    finished_d, aborted_d, low_two_d, low_three_d;

	logic [CMP_W-1:0] low_x, conv_x, high_x, delta_x;
	logic             plugged, in_window, precharging;

	// Handshakes: result register frees as it is taken
	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!res_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(res_q);

	// Config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_delta_q  <= CFG_W'(20);
			batt_level_q  <= '0;
			limit_ticks_q <= CFG_W'(1000);
			byp_start_q   <= '1;
			byp_stop_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_STOP_DELTA:   stop_delta_q  <= cfg_data;
				REG_BATT_LEVEL:   batt_level_q  <= cfg_data;
				REG_LIMIT_TICKS:  limit_ticks_q <= cfg_data;
				REG_BYPASS_START: byp_start_q   <= cfg_data;
				REG_BYPASS_STOP:  byp_stop_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			tick_s1.mode                <= s_axis_tuser;
			tick_s1.low_side_volts      <= s_axis_tdata[LOW_LSB +: VOLT_WIDTH];
			tick_s1.converter_low_volts <= s_axis_tdata[CONV_LSB +: VOLT_WIDTH];
			tick_s1.high_side_volts     <= s_axis_tdata[HIGH_LSB +: VOLT_WIDTH];
			tick_s1.bypass_request      <= s_axis_tdata[REQ_BIT];
			tick_s1.error_reset         <= s_axis_tdata[ERR_BIT];
		end
	end

	// Widened operands: window bounds never wrap
	assign low_x   = CMP_W'(tick_s1.low_side_volts);
	assign conv_x  = CMP_W'(tick_s1.converter_low_volts);
	assign high_x  = CMP_W'(tick_s1.high_side_volts);
	assign delta_x = CMP_W'(stop_delta_q);

	assign plugged     = low_x >= CMP_W'(batt_level_q);
	assign in_window   = ((low_x + delta_x) > conv_x) && (low_x < (conv_x + delta_x));
	assign precharging = plugged && !aborted_q &&
		(tick_s1.mode == MODE_BOOST || tick_s1.mode == MODE_BUCK);

	// Sequencing logic for one tick
	always_comb begin
		close_two_tmr_d  = close_two_tmr_q;
		open_one_tmr_d   = open_one_tmr_q;
		open_one_pend_d  = open_one_pend_q;
		abort_tmr_d      = abort_tmr_q;
		bypass_tmr_d     = bypass_tmr_q;
		hold_two_tmr_d   = hold_two_tmr_q;
		hold_three_tmr_d = hold_three_tmr_q;
		cmd_one_d        = cmd_one_q;
		cmd_two_d        = cmd_two_q;
		cmd_three_d      = cmd_three_q;
		finished_d       = finished_q;
		aborted_d        = aborted_q;
		low_two_d        = low_two_q;
		low_three_d      = low_three_q;

		// Precharge: S1 and S2
		if (precharging) begin
			if (in_window) begin
				if (close_two_tmr_q >= RELAY_MAX) begin
					cmd_two_d       = 1'b1;
					close_two_tmr_d = '0;
					open_one_pend_d = 1'b1;
				end else begin
					close_two_tmr_d = close_two_tmr_q + 1'b1;
				end
				if (open_one_pend_d) begin
					if (open_one_tmr_q >= RELAY_MAX) begin
						cmd_one_d       = 1'b0;
						finished_d      = 1'b1;
						open_one_tmr_d  = '0;
						open_one_pend_d = 1'b0;
					end else begin
						open_one_tmr_d = open_one_tmr_q + 1'b1;
					end
				end
			end else begin
				cmd_one_d  = 1'b1;
				finished_d = 1'b0;
				if (abort_tmr_q >= limit_ticks_q) begin
					aborted_d   = 1'b1;
					abort_tmr_d = '0;
				end else begin
					abort_tmr_d = abort_tmr_q + 1'b1;
					aborted_d   = 1'b0;
				end
			end
		end else if (tick_s1.mode == MODE_BUCK) begin
			cmd_two_d  = 1'b1;
			cmd_one_d  = 1'b0;
			finished_d = 1'b1;
		end

		// Bypass: S3
		if (tick_s1.mode == MODE_BYPASS) begin
			cmd_three_d = tick_s1.bypass_request;
		end else begin
			if (high_x > CMP_W'(byp_start_q) && tick_s1.mode != MODE_BOOST) begin
				if (bypass_tmr_q >= BYPASS_MAX) begin
					cmd_three_d  = 1'b1;
					bypass_tmr_d = '0;
				end else begin
					bypass_tmr_d = bypass_tmr_q + 1'b1;
				end
			end
			if (high_x < CMP_W'(byp_stop_q))
				cmd_three_d = 1'b0;
		end

		// Hold duty for S3 and S2
		if (cmd_three_d) begin
			if (hold_three_tmr_q >= HOLD_MAX)
				low_three_d = 1'b1;
			else
				hold_three_tmr_d = hold_three_tmr_q + 1'b1;
		end else begin
			low_three_d      = 1'b0;
			hold_three_tmr_d = '0;
		end
		if (cmd_two_d) begin
			if (hold_two_tmr_q >= HOLD_MAX)
				low_two_d = 1'b1;
			else
				hold_two_tmr_d = hold_two_tmr_q + 1'b1;
		end else begin
			low_two_d      = 1'b0;
			hold_two_tmr_d = '0;
		end

		// Error reset clears the abort flag within this tick
		if (tick_s1.error_reset)
			aborted_d = 1'b0;
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_two_tmr_q  <= '0;
			open_one_tmr_q   <= '0;
			open_one_pend_q  <= 1'b0;
			abort_tmr_q      <= '0;
			bypass_tmr_q     <= '0;
			hold_two_tmr_q   <= '0;
			hold_three_tmr_q <= '0;
			cmd_one_q        <= 1'b0;
			cmd_two_q        <= 1'b0;
			cmd_three_q      <= 1'b0;
			finished_q       <= 1'b0;
			aborted_q        <= 1'b0;
			low_two_q        <= 1'b0;
			low_three_q      <= 1'b0;
		end else if (advance) begin
			close_two_tmr_q  <= close_two_tmr_d;
			open_one_tmr_q   <= open_one_tmr_d;
			open_one_pend_q  <= open_one_pend_d;
			abort_tmr_q      <= abort_tmr_d;
			bypass_tmr_q     <= bypass_tmr_d;
			hold_two_tmr_q   <= hold_two_tmr_d;
			hold_three_tmr_q <= hold_three_tmr_d;
			cmd_one_q        <= cmd_one_d;
			cmd_two_q        <= cmd_two_d;
			cmd_three_q      <= cmd_three_d;
			finished_q       <= finished_d;
			aborted_q        <= aborted_d;
			low_two_q        <= low_two_d;
			low_three_q      <= low_three_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.relay_one_closed     <= cmd_one_d;
			res_q.relay_two_closed     <= cmd_two_d;
			res_q.relay_three_closed   <= cmd_three_d;
			res_q.precharge_finished   <= finished_d;
			res_q.precharge_abort_flag <= aborted_d;
			res_q.two_low_duty         <= low_two_d;
			res_q.three_low_duty       <= low_three_d;
		end
	end

endmodule
`default_nettype wire
